>>> src/revisioned_occupancy_grid_top_defines.svh
// Assertion macros for the occupancy grid checker.
// Depends on nothing; the asserting module must have aclk and aresetn in scope.
`ifndef REVISIONED_OCCUPANCY_GRID_TOP_DEFINES_SVH
`define REVISIONED_OCCUPANCY_GRID_TOP_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted
`define ROG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset
`define ROG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

>>> src/rog_pkg.sv
// Shared types and constants of the revisioned occupancy grid.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps

package rog_pkg;

    // Command codes
    localparam logic [1:0] CMD_MARK  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELDS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCLE = 3'd4;

    // Field widths
    localparam int FIELD_IDX_W = 5;
    localparam int RAW_SIZE_W  = 7;
    localparam int REV_W       = 15;
    localparam int FRAC_BITS   = 12;
    localparam int SCALED_W    = 33;
    localparam int PROD_W      = 34;
    localparam int CELL_W      = PROD_W - FRAC_BITS;

    localparam logic [REV_W-1:0] REVISION_LIMIT   = 15'd32000;
    localparam logic [15:0]      UNITY_RECIPROCAL = 16'd256;

    localparam logic [4:0]  FIELDS_RST  = 5'd16;
    localparam logic [6:0]  ROWS_RST    = 7'd64;
    localparam logic [6:0]  COLS_RST    = 7'd64;
    localparam logic [15:0] INV_RED_RST = 16'd256;

    typedef struct packed {
        logic [1:0]             command;
        logic [FIELD_IDX_W-1:0] field_index;
        logic signed [15:0]     x_pos;
        logic signed [15:0]     y_pos;
        logic [15:0]            radius;
    } rog_in_t;

    typedef struct packed {
        logic occupied;
        logic store_wiped;
    } rog_out_t;

    typedef enum logic [3:0] {
        ST_WIPE,
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_R,
        ST_FLOOR,
        ST_BND_XLO,
        ST_BND_XHI,
        ST_BND_YLO,
        ST_BND_YHI,
        ST_BASE,
        ST_MARK,
        ST_READ,
        ST_WAIT,
        ST_DONE
    } rog_state_t;

endpackage

>>> src/rog_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module rog_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 65536,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/revisioned_occupancy_grid_top.sv
// Top level of the revisioned occupancy grid: sequencer, shared datapath, stamp RAM.
// Depends on rog_pkg and rog_ram.
`timescale 1ns / 1ps

// Usage
//   Input words arrive on s_valid/s_ready/s_data: mark a square, query a point or
//   clear by advancing the revision. Every input word yields exactly one result
//   word on m_valid/m_ready/m_data. Registers are written through cfg_we,
//   cfg_index and cfg_wdata by the user only while the block is idle (not enforced).
// Sequencing (one word at a time, s_ready only in the idle state)
//   A clear below the revision limit, an unused command or a plane out of range
//   goes straight to its result; the next word is taken once a result enters the
//   output register. One shared 17x17 multiplier scales x, y and, for a mark, the
//   half side in turn, one shared add/clamp unit forms the bounds, and the single
//   RAM write port stamps one cell a cycle. A clear that passes revision 32000
//   sweeps the whole store of MAX_FIELDS * MAX_ROWS * MAX_COLS entries (65536 at
//   the defaults), one entry a cycle, before it reports.
// Reset: aresetn is synchronous, active low; the same sweep then zeroes the store
//   with s_ready low. Register writes are taken throughout.
// Stalls: a result waits in the output register while m_ready is low; the next
//   word may be accepted and worked on, but its result is held back until then.

module revisioned_occupancy_grid_top #(
    parameter int MAX_FIELDS = 16,
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rog_pkg::rog_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output rog_pkg::rog_out_t                m_data,
    input  logic                             cfg_we,
    input  logic [rog_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rog_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import rog_pkg::*;

    localparam int DEPTH   = MAX_FIELDS * MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int BW      = $clog2(MAX_DIM + 1);
    localparam int LW      = (BW > RAW_SIZE_W) ? BW : RAW_SIZE_W;
    localparam int FCW_RAW = $clog2(MAX_FIELDS + 1);
    localparam int FCW     = (FCW_RAW > FIELD_IDX_W) ? FCW_RAW : FIELD_IDX_W;

    // Sequencer
    rog_state_t state_reg, state_next;

    // Configuration registers
    logic [4:0]  fields_in_use_reg;
    logic [6:0]  rows_in_use_reg;
    logic [6:0]  cols_in_use_reg;
    logic [15:0] inverse_reduction_reg;
    logic [15:0] min_scale_reg;

    // Captured input word
    logic [1:0]             cmd_reg, cmd_next;
    logic [FIELD_IDX_W-1:0] fld_reg, fld_next;
    logic signed [15:0]     x_reg, x_next;
    logic signed [15:0]     y_reg, y_next;
    logic [15:0]            r_reg, r_next;

    // Scaled values, 12 fraction bits
    logic signed [SCALED_W-1:0] xs_reg, xs_next;
    logic signed [SCALED_W-1:0] ys_reg, ys_next;
    logic signed [SCALED_W-1:0] rs_reg, rs_next;

    // Bounds and walk position
    logic [BW-1:0]     xlo_reg, xlo_next;
    logic [BW-1:0]     xhi_reg, xhi_next;
    logic [BW-1:0]     ylo_reg, ylo_next;
    logic [BW-1:0]     yhi_reg, yhi_next;
    logic [BW-1:0]     col_reg, col_next;
    logic [BW-1:0]     row_reg, row_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] wipe_cnt_reg, wipe_cnt_next;
    logic              wipe_cmd_reg, wipe_cmd_next;

    // Revision and results
    logic [REV_W-1:0] rev_reg, rev_next;
    logic             res_occ_reg, res_occ_next;
    logic             res_wiped_reg, res_wiped_next;
    logic             m_valid_reg, m_valid_next;
    rog_out_t         m_data_reg, m_data_next;

    // Combinational datapath
    logic [FCW-1:0]             fld_lim;
    logic                       fld_oor;
    logic [LW-1:0]              row_lim_w, col_lim_w;
    logic [BW-1:0]              row_lim, col_lim;
    logic [REV_W-1:0]           rev_inc;
    logic                       rev_wrap;
    logic signed [16:0]         mul_a, mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [SCALED_W-1:0] floor_v;
    logic                       bnd_is_x, bnd_is_hi;
    logic signed [SCALED_W-1:0] bnd_a;
    logic signed [PROD_W-1:0]   bnd_sum;
    logic [CELL_W-1:0]          bnd_cell;
    logic [BW-1:0]              bnd_size, bnd_size_m1, bnd_lo_in, bnd_lo_p1;
    logic [BW-1:0]              bnd_lo_val, bnd_hi_val;
    logic [BW-1:0]              col_inc, row_inc;
    logic                       wipe_last, mark_last, is_mark, out_free;
    logic [ADDR_W-1:0]          cell_addr;

    // RAM port signals
    logic              ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [REV_W-1:0]  ram_wr_data, ram_rd_data;

    // Saturate the grid sizes and check the plane index
    always_comb begin
        fld_lim = (FCW'(fields_in_use_reg) > FCW'(MAX_FIELDS)) ?
                  FCW'(MAX_FIELDS) : FCW'(fields_in_use_reg);
        fld_oor = FCW'(s_data.field_index) >= fld_lim;

        if (rows_in_use_reg == '0) begin
            row_lim_w = LW'(1);
        end else if (LW'(rows_in_use_reg) > LW'(MAX_ROWS)) begin
            row_lim_w = LW'(MAX_ROWS);
        end else begin
            row_lim_w = LW'(rows_in_use_reg);
        end
        if (cols_in_use_reg == '0) begin
            col_lim_w = LW'(1);
        end else if (LW'(cols_in_use_reg) > LW'(MAX_COLS)) begin
            col_lim_w = LW'(MAX_COLS);
        end else begin
            col_lim_w = LW'(cols_in_use_reg);
        end
        row_lim = row_lim_w[BW-1:0];
        col_lim = col_lim_w[BW-1:0];
    end

    // Shared multiplier: x, y, then half side, each times the reciprocal
    always_comb begin
        unique case (state_reg)
            ST_MUL_X: mul_a = {x_reg[15], x_reg};
            ST_MUL_Y: mul_a = {y_reg[15], y_reg};
            default:  mul_a = signed'({1'b0, r_reg});
        endcase
        mul_b   = signed'({1'b0, inverse_reduction_reg});
        prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
        floor_v = signed'({9'd0, min_scale_reg, 8'd0});
    end

    // Shared bound unit: add or subtract the half side, take the cell, clamp
    always_comb begin
        bnd_is_x  = (state_reg == ST_BND_XLO) || (state_reg == ST_BND_XHI);
        bnd_is_hi = (state_reg == ST_BND_XHI) || (state_reg == ST_BND_YHI);
        bnd_a     = bnd_is_x ? xs_reg : ys_reg;
        if (bnd_is_hi) begin
            bnd_sum = PROD_W'(bnd_a) + PROD_W'(rs_reg);
        end else begin
            bnd_sum = PROD_W'(bnd_a) - PROD_W'(rs_reg);
        end
        bnd_cell    = bnd_sum[PROD_W-1] ? '0 : bnd_sum[PROD_W-1:FRAC_BITS];
        bnd_size    = bnd_is_x ? col_lim : row_lim;
        bnd_size_m1 = bnd_size - BW'(1);
        bnd_lo_in   = bnd_is_x ? xlo_reg : ylo_reg;
        bnd_lo_p1   = bnd_lo_in + BW'(1);
        bnd_lo_val  = (bnd_cell > CELL_W'(bnd_size_m1)) ? bnd_size_m1 : bnd_cell[BW-1:0];
        if (bnd_cell < CELL_W'(bnd_lo_p1)) begin
            bnd_hi_val = bnd_lo_p1;
        end else if (bnd_cell > CELL_W'(bnd_size)) begin
            bnd_hi_val = bnd_size;
        end else begin
            bnd_hi_val = bnd_cell[BW-1:0];
        end
    end

    // Walk and sweep status
    always_comb begin
        is_mark   = (cmd_reg == CMD_MARK);
        rev_inc   = rev_reg + REV_W'(1);
        rev_wrap  = rev_inc > REVISION_LIMIT;
        col_inc   = col_reg + BW'(1);
        row_inc   = row_reg + BW'(1);
        wipe_last = (wipe_cnt_reg == ADDR_W'(DEPTH - 1));
        mark_last = (col_inc == xhi_reg) && (row_inc == yhi_reg);
        out_free  = !m_valid_reg || m_ready;
        cell_addr = base_reg + ADDR_W'(col_reg);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_WIPE: begin
                if (wipe_last) begin
                    state_next = wipe_cmd_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.command)
                        CMD_MARK:  state_next = fld_oor ? ST_DONE : ST_MUL_X;
                        CMD_QUERY: state_next = fld_oor ? ST_DONE : ST_MUL_X;
                        CMD_CLEAR: state_next = rev_wrap ? ST_WIPE : ST_DONE;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_MUL_X:   state_next = ST_MUL_Y;
            ST_MUL_Y:   state_next = is_mark ? ST_MUL_R : ST_BND_XLO;
            ST_MUL_R:   state_next = ST_FLOOR;
            ST_FLOOR:   state_next = ST_BND_XLO;
            ST_BND_XLO: state_next = is_mark ? ST_BND_XHI : ST_BND_YLO;
            ST_BND_XHI: state_next = ST_BND_YLO;
            ST_BND_YLO: state_next = is_mark ? ST_BND_YHI : ST_BASE;
            ST_BND_YHI: state_next = ST_BASE;
            ST_BASE:    state_next = is_mark ? ST_MARK : ST_READ;
            ST_MARK: begin
                if (mark_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:    state_next = ST_WAIT;
            ST_WAIT:    state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        cmd_next       = cmd_reg;
        fld_next       = fld_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        r_next         = r_reg;
        xs_next        = xs_reg;
        ys_next        = ys_reg;
        rs_next        = rs_reg;
        xlo_next       = xlo_reg;
        xhi_next       = xhi_reg;
        ylo_next       = ylo_reg;
        yhi_next       = yhi_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        base_next      = base_reg;
        wipe_cnt_next  = wipe_cnt_reg;
        wipe_cmd_next  = wipe_cmd_reg;
        rev_next       = rev_reg;
        res_occ_next   = res_occ_reg;
        res_wiped_next = res_wiped_reg;
        m_data_next    = m_data_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = cell_addr;
        ram_wr_data    = rev_inc;
        ram_rd_en      = 1'b0;

        unique case (state_reg)
            ST_WIPE: begin
                // Zero one entry a cycle
                ram_wr_en     = 1'b1;
                ram_wr_addr   = wipe_cnt_reg;
                ram_wr_data   = '0;
                wipe_cnt_next = wipe_cnt_reg + ADDR_W'(1);
            end
            ST_IDLE: begin
                // Capture the word and settle the cheap commands here
                if (s_valid) begin
                    cmd_next       = s_data.command;
                    fld_next       = s_data.field_index;
                    x_next         = s_data.x_pos;
                    y_next         = s_data.y_pos;
                    r_next         = s_data.radius;
                    rs_next        = '0;
                    res_occ_next   = (s_data.command == CMD_QUERY) && fld_oor;
                    res_wiped_next = 1'b0;
                    if (s_data.command == CMD_CLEAR) begin
                        if (rev_wrap) begin
                            rev_next       = '0;
                            wipe_cnt_next  = '0;
                            wipe_cmd_next  = 1'b1;
                            res_wiped_next = 1'b1;
                        end else begin
                            rev_next = rev_inc;
                        end
                    end
                end
            end
            ST_MUL_X:   xs_next = prod[SCALED_W-1:0];
            ST_MUL_Y:   ys_next = prod[SCALED_W-1:0];
            ST_MUL_R:   rs_next = prod[SCALED_W-1:0];
            ST_FLOOR: begin
                // Floor the half side only when scaling applies
                if ((inverse_reduction_reg != UNITY_RECIPROCAL) && (rs_reg < floor_v)) begin
                    rs_next = floor_v;
                end
            end
            ST_BND_XLO: xlo_next = bnd_lo_val;
            ST_BND_XHI: xhi_next = bnd_hi_val;
            ST_BND_YLO: ylo_next = bnd_lo_val;
            ST_BND_YHI: yhi_next = bnd_hi_val;
            ST_BASE: begin
                base_next = (ADDR_W'(fld_reg) * ADDR_W'(MAX_ROWS) + ADDR_W'(ylo_reg))
                            * ADDR_W'(MAX_COLS);
                col_next  = xlo_reg;
                row_next  = ylo_reg;
            end
            ST_MARK: begin
                // Stamp one cell, advance along the row, then to the next row
                ram_wr_en = 1'b1;
                if (col_inc == xhi_reg) begin
                    col_next  = xlo_reg;
                    row_next  = row_inc;
                    base_next = base_reg + ADDR_W'(MAX_COLS);
                end else begin
                    col_next = col_inc;
                end
            end
            ST_READ:    ram_rd_en = 1'b1;
            ST_WAIT:    res_occ_next = ram_rd_data > rev_reg;
            ST_DONE: begin
                if (out_free) begin
                    m_data_next.occupied    = res_occ_reg;
                    m_data_next.store_wiped = res_wiped_reg;
                    wipe_cmd_next           = 1'b0;
                end
            end
            default: begin
            end
        endcase

        // Output word valid
        if ((state_reg == ST_DONE) && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_WIPE;
            wipe_cnt_reg  <= '0;
            wipe_cmd_reg  <= 1'b0;
            rev_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wipe_cnt_reg  <= wipe_cnt_next;
            wipe_cmd_reg  <= wipe_cmd_next;
            rev_reg       <= rev_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fields_in_use_reg     <= FIELDS_RST;
            rows_in_use_reg       <= ROWS_RST;
            cols_in_use_reg       <= COLS_RST;
            inverse_reduction_reg <= INV_RED_RST;
            min_scale_reg         <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FIELDS:   fields_in_use_reg     <= cfg_wdata[4:0];
                CFG_ROWS:     rows_in_use_reg       <= cfg_wdata[6:0];
                CFG_COLS:     cols_in_use_reg       <= cfg_wdata[6:0];
                CFG_INV_RED:  inverse_reduction_reg <= cfg_wdata;
                CFG_MIN_SCLE: min_scale_reg         <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        fld_reg       <= fld_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        r_reg         <= r_next;
        xs_reg        <= xs_next;
        ys_reg        <= ys_next;
        rs_reg        <= rs_next;
        xlo_reg       <= xlo_next;
        xhi_reg       <= xhi_next;
        ylo_reg       <= ylo_next;
        yhi_reg       <= yhi_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        base_reg      <= base_next;
        res_occ_reg   <= res_occ_next;
        res_wiped_reg <= res_wiped_next;
        m_data_reg    <= m_data_next;
    end

    // Stamp store
    rog_ram #(
        .WIDTH (REV_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (cell_addr),
        .rd_data (ram_rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> src/rog_checker.sv
// Port-level checker for the occupancy grid top level, bound to it below.
// Depends on rog_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "revisioned_occupancy_grid_top_defines.svh"

module rog_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input rog_pkg::rog_out_t m_data
);

    // Held result word stays offered and unchanged
    `ROG_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid, "result word dropped while stalled")
    `ROG_ASSERT(a_out_stable, m_valid && !m_ready |=> $stable(m_data), "result word changed while stalled")

    // One word in flight: ready falls after each acceptance
    `ROG_ASSERT(a_one_word, s_valid && s_ready |=> !s_ready, "second word accepted while busy")

    // A wipe result never reports an occupied cell
    `ROG_ASSERT(a_flags_excl, m_valid |-> !(m_data.occupied && m_data.store_wiped), "occupied and wiped both set")

    // The clearing sweep holds off input right after reset
    `ROG_ASSERT_ALWAYS(a_reset_sweep, $past(!aresetn) |-> !s_ready, "input taken before the store was cleared")

endmodule

bind revisioned_occupancy_grid_top rog_checker u_rog_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
